[src/utf8_to_utf16_crlf_decoder_top_macros.svh]
// Assertion macros shared by the checker of the UTF-8 to UTF-16 decoder.
// Used by src/u8u16_chk.sv; expects clk and rst_n in scope.
`ifndef UTF8_TO_UTF16_CRLF_DECODER_TOP_MACROS_SVH
`define UTF8_TO_UTF16_CRLF_DECODER_TOP_MACROS_SVH

// Implication checked at every edge outside reset.
`define U8U16_ASSERT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Implication checked in the cycle after the condition.
`define U8U16_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

[src/u8u16_pkg.sv]
// Types and constants of the UTF-8 to UTF-16 decoder.
// No dependencies; imported by utf8_to_utf16_crlf_decoder_top.
package u8u16_pkg;

  localparam logic [7:0]  CHAR_CR   = 8'h0D;
  localparam logic [7:0]  CHAR_LF   = 8'h0A;
  localparam logic [15:0] CAP_RESET = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [0:0] {
    REG_CRLF_MODE = 1'b0,
    REG_CAPACITY  = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    STOP_INPUT_END = 3'd0,
    STOP_ZERO_BYTE = 3'd1,
    STOP_BAD_LEAD  = 3'd2,
    STOP_FULL      = 3'd3,
    STOP_TRUNCATED = 3'd4
  } stop_reason_t;

  typedef enum logic [0:0] {
    KIND_UNIT   = 1'b0,
    KIND_STATUS = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t   item_kind;
    logic [15:0]  code_unit;
    logic [15:0]  units_total;
    stop_reason_t stop_reason;
    logic         last_item;
  } result_t;

endpackage

[src/utf8_to_utf16_crlf_decoder_top.sv]
// UTF-8 to UTF-16 stream decoder with optional LF to CR LF conversion.
// Depends on u8u16_pkg.
//
//  channel | dir | tdata                                   | tuser     | tlast
//  in_     | in  | data_byte[7:0]                          | -         | end_of_string
//  out_    | out | code_unit[15:0] units_total[31:16]      | item_kind | last_item
//          |     | stop_reason[34:32]                      |           |
//  cfg_    | in  | cfg_index selects register, cfg_data    | -         | -
//
// One input byte per cycle while in_tready is high. Each byte is decoded in the cycle it
// is accepted and its zero to three results land in a four-entry result queue, drained
// one per cycle while out_tready is high. in_tready is high while the queue holds at
// most one result, so the output port sets the rate when bytes give several results.
// Reset (rst_n low, synchronous) empties the queue and clears the string state;
// crlf_mode returns to 1 and capacity_units to 65535. cfg_ready is always high.
module utf8_to_utf16_crlf_decoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  logic                          in_tlast,   // end_of_string
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // [15:0] code_unit, [31:16] units_total,
                                                    // [34:32] stop_reason, [39:35] zero
  output logic                          out_tuser,  // [0] item_kind
  output logic                          out_tlast,  // last_item
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  u8u16_pkg::reg_index_t         cfg_index,
  input  logic [15:0]                   cfg_data
);
  import u8u16_pkg::*;

  // configuration
  logic        crlf_r;
  logic [15:0] cap_r;

  // string state
  logic [20:0]  partial_r, partial_nxt;
  logic [1:0]   pend_r, pend_nxt;
  logic         held_r, held_nxt;
  logic         stopped_r, stopped_nxt;
  stop_reason_t stop_code_r, stop_code_nxt;
  logic [15:0]  uw_r, uw_nxt;

  // result queue
  result_t              queue_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]    cnt_r, cnt_nxt;

  result_t     items [3];
  logic [1:0]  n_items;

  logic        accept, pop;
  logic [7:0]  b;
  logic        eos;

  assign b          = in_tdata;
  assign eos        = in_tlast;
  assign in_tready  = (cnt_r <= (QUEUE_AW+1)'(1));
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign cfg_ready  = 1'b1;

  assign out_tdata = {5'd0, queue_r[rd_ptr_r].stop_reason,
                      queue_r[rd_ptr_r].units_total, queue_r[rd_ptr_r].code_unit};
  assign out_tuser = queue_r[rd_ptr_r].item_kind;
  assign out_tlast = queue_r[rd_ptr_r].last_item;

  // Decode one byte against the current string state.
  always_comb begin
    logic         emit_v;
    logic [20:0]  code_v;
    logic         halt_v;
    stop_reason_t halt_rsn;
    logic         skip_v;
    logic         lead_v;
    logic [1:0]   wcnt;
    logic [15:0]  wu0, wu1;

    partial_nxt   = partial_r;
    pend_nxt      = pend_r;
    held_nxt      = held_r;
    stopped_nxt   = stopped_r;
    stop_code_nxt = stop_code_r;
    uw_nxt        = uw_r;
    n_items       = 2'd0;
    for (int k = 0; k < 3; k++) items[k] = '0;
    emit_v   = 1'b0;
    code_v   = '0;
    halt_v   = 1'b0;
    halt_rsn = STOP_INPUT_END;
    skip_v   = 1'b0;
    lead_v   = 1'b0;
    wcnt     = 2'd0;
    wu0      = '0;
    wu1      = '0;

    if (!stopped_r) begin
      if (pend_r != 2'd0) begin
        partial_nxt = {partial_r[14:0], b[5:0]};
        pend_nxt    = pend_r - 2'd1;
        if (pend_nxt == 2'd0) begin
          emit_v      = 1'b1;
          code_v      = partial_nxt;
          partial_nxt = '0;
        end else if (eos) begin
          halt_v   = 1'b1;
          halt_rsn = STOP_TRUNCATED;
        end
      end else begin
        // Resolve a held CR: drop it before an LF byte, else write it first.
        if (held_r) begin
          held_nxt = 1'b0;
          if (b != CHAR_LF) begin
            if ({1'b0, uw_nxt} + 17'd1 > {1'b0, cap_r}) begin
              halt_v   = 1'b1;
              halt_rsn = STOP_FULL;
              skip_v   = 1'b1;
            end else begin
              items[n_items].code_unit = {8'd0, CHAR_CR};
              n_items = n_items + 2'd1;
              uw_nxt  = uw_nxt + 16'd1;
            end
          end
        end
        if (!skip_v) begin
          if (b == 8'd0) begin
            halt_v   = 1'b1;
            halt_rsn = STOP_ZERO_BYTE;
          end else begin
            case (b[7:4])
              4'h8, 4'h9, 4'hA, 4'hB: begin
                halt_v   = 1'b1;
                halt_rsn = STOP_BAD_LEAD;
              end
              4'hC, 4'hD: begin
                partial_nxt = {16'd0, b[4:0]};
                pend_nxt    = 2'd1;
                lead_v      = 1'b1;
              end
              4'hE: begin
                partial_nxt = {17'd0, b[3:0]};
                pend_nxt    = 2'd2;
                lead_v      = 1'b1;
              end
              4'hF: begin
                partial_nxt = {18'd0, b[2:0]};
                pend_nxt    = 2'd3;
                lead_v      = 1'b1;
              end
              default: begin
                emit_v = 1'b1;
                code_v = {13'd0, b};
              end
            endcase
            if (lead_v && eos) begin
              halt_v   = 1'b1;
              halt_rsn = STOP_TRUNCATED;
            end
          end
        end
      end

      if (emit_v) begin
        if (!crlf_r) begin
          wcnt = 2'd1;
          wu0  = code_v[15:0];
        end else if (code_v == {13'd0, CHAR_CR} && !eos) begin
          held_nxt = 1'b1;
        end else if (code_v == {13'd0, CHAR_LF}) begin
          wcnt = 2'd2;
          wu0  = {8'd0, CHAR_CR};
          wu1  = {8'd0, CHAR_LF};
        end else if (code_v[20:16] == 5'd0) begin
          wcnt = 2'd1;
          wu0  = code_v[15:0];
        end
        // An LF pair goes out whole or not at all.
        if (wcnt != 2'd0) begin
          if ({1'b0, uw_nxt} + {15'd0, wcnt} > {1'b0, cap_r}) begin
            halt_v   = 1'b1;
            halt_rsn = STOP_FULL;
          end else begin
            items[n_items].code_unit = wu0;
            n_items = n_items + 2'd1;
            if (wcnt == 2'd2) begin
              items[n_items].code_unit = wu1;
              n_items = n_items + 2'd1;
            end
            uw_nxt = uw_nxt + {14'd0, wcnt};
          end
        end
      end

      if (halt_v) begin
        stopped_nxt   = 1'b1;
        stop_code_nxt = halt_rsn;
        held_nxt      = 1'b0;
        pend_nxt      = 2'd0;
        partial_nxt   = '0;
      end
    end

    if (eos) begin
      items[n_items].item_kind   = KIND_STATUS;
      items[n_items].units_total = uw_nxt;
      items[n_items].stop_reason = stopped_nxt ? stop_code_nxt : STOP_INPUT_END;
      n_items       = n_items + 2'd1;
      partial_nxt   = '0;
      pend_nxt      = 2'd0;
      held_nxt      = 1'b0;
      stopped_nxt   = 1'b0;
      stop_code_nxt = STOP_INPUT_END;
      uw_nxt        = '0;
    end

    if (n_items != 2'd0) items[n_items - 2'd1].last_item = 1'b1;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) cnt_nxt = cnt_nxt + (QUEUE_AW+1)'(n_items);
    if (pop)    cnt_nxt = cnt_nxt - (QUEUE_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crlf_r      <= 1'b1;
      cap_r       <= CAP_RESET;
      partial_r   <= '0;
      pend_r      <= '0;
      held_r      <= 1'b0;
      stopped_r   <= 1'b0;
      stop_code_r <= STOP_INPUT_END;
      uw_r        <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CRLF_MODE: crlf_r <= cfg_data[0];
          REG_CAPACITY:  cap_r  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        partial_r   <= partial_nxt;
        pend_r      <= pend_nxt;
        held_r      <= held_nxt;
        stopped_r   <= stopped_nxt;
        stop_code_r <= stop_code_nxt;
        uw_r        <= uw_nxt;
        wr_ptr_r    <= wr_ptr_r + QUEUE_AW'(n_items);
      end
      if (pop) rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // Queue payload: push the decoded results in order.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < n_items) queue_r[wr_ptr_r + QUEUE_AW'(k)] <= items[k];
      end
    end
  end

endmodule

[src/u8u16_chk.sv]
// Port-level checker for the UTF-8 to UTF-16 decoder, bound to the top level.
// Depends on u8u16_pkg and utf8_to_utf16_crlf_decoder_top_macros.svh.
`include "utf8_to_utf16_crlf_decoder_top_macros.svh"

module u8u16_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [7:0]            in_tdata,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [39:0]           out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input u8u16_pkg::reg_index_t cfg_index,
  input logic [15:0]           cfg_data
);
  import u8u16_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_tvalid, in_tready, in_tdata, in_tlast, cfg_valid, cfg_ready,
                       cfg_index, cfg_data};

  // A stalled result holds.
  `U8U16_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast),
    "result changed while stalled")

  // The status item closes the results of its byte.
  `U8U16_ASSERT(a_status_last, out_tvalid && out_tuser == KIND_STATUS, out_tlast,
    "status item not marked last")

  `U8U16_ASSERT(a_status_fields, out_tvalid && out_tuser == KIND_STATUS,
    out_tdata[15:0] == 16'd0 && out_tdata[34:32] <= STOP_TRUNCATED,
    "status item carries a code unit or bad stop reason")

  `U8U16_ASSERT(a_unit_fields, out_tvalid && out_tuser == KIND_UNIT,
    out_tdata[34:16] == 19'd0, "code unit item carries status fields")

  `U8U16_ASSERT(a_pad_zero, out_tvalid, out_tdata[39:35] == 5'd0,
    "padding bits not zero")

endmodule

bind utf8_to_utf16_crlf_decoder_top u8u16_chk u_chk (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for utf8_to_utf16_crlf_decoder_top: UTF-8 byte strings go in,
// and each UTF-16 unit and string status is matched against a decoder model kept here.
// Depends on u8u16_pkg and the decoder RTL only.
module testbench;
  import u8u16_pkg::*;

  localparam int RANDOM_BYTES  = 180;
  localparam int HOLD_CYCLES   = 200;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_index_t  cfg_index = REG_CRLF_MODE;
  logic [15:0] cfg_data = '0;

  // decoder model: registers and per-string state
  logic         crlf_on;
  logic [15:0]  cap_limit;
  logic [20:0]  code_acc;
  logic [1:0]   cont_left;
  logic         cr_held;
  logic         halted;
  stop_reason_t halt_why;
  logic [15:0]  units_out;

  result_t      byte_results[$];
  result_t      awaited_items[$];
  result_t      head_item;
  logic [7:0]   str_bytes[$];

  int errors = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int items_checked = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;
  int rx_hold_left = 0;
  int rx_stall_left = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;

  utf8_to_utf16_crlf_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- decoder model

  function automatic void clear_string();
    code_acc  = '0;
    cont_left = '0;
    cr_held   = 1'b0;
    halted    = 1'b0;
    halt_why  = STOP_INPUT_END;
    units_out = '0;
  endfunction

  function automatic void add_result(item_kind_t kind, logic [15:0] unit,
                                     logic [15:0] total, stop_reason_t why);
    result_t r;
    r.item_kind   = kind;
    r.code_unit   = unit;
    r.units_total = total;
    r.stop_reason = why;
    r.last_item   = 1'b0;
    byte_results = {byte_results, r};
  endfunction

  function automatic void stop_string(stop_reason_t why);
    halted    = 1'b1;
    halt_why  = why;
    cr_held   = 1'b0;
    cont_left = '0;
    code_acc  = '0;
  endfunction

  // Write one or two units, or stop the string when they do not both fit.
  function automatic bit put_units(int count, logic [15:0] u0, logic [15:0] u1);
    if (int'(units_out) + count > int'(cap_limit)) begin
      stop_string(STOP_FULL);
      return 1'b0;
    end
    add_result(KIND_UNIT, u0, 16'h0, STOP_INPUT_END);
    if (count == 2)
      add_result(KIND_UNIT, u1, 16'h0, STOP_INPUT_END);
    units_out = units_out + 16'(count);
    return 1'b1;
  endfunction

  function automatic void emit_code_point(logic [20:0] cp, bit eos);
    if (!crlf_on) begin
      void'(put_units(1, cp[15:0], 16'h0));
      return;
    end
    if (cp == 21'(CHAR_CR) && !eos) begin
      cr_held = 1'b1;
      return;
    end
    if (cp == 21'(CHAR_LF)) begin
      void'(put_units(2, 16'(CHAR_CR), 16'(CHAR_LF)));
      return;
    end
    // wide code points vanish in line-ending mode
    if (cp > 21'h00FFFF)
      return;
    void'(put_units(1, cp[15:0], 16'h0));
  endfunction

  function automatic void take_byte(logic [7:0] b, bit eos);
    logic [20:0] cp;
    if (cont_left != 0) begin
      code_acc  = {code_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 0) begin
        cp       = code_acc;
        code_acc = '0;
        emit_code_point(cp, eos);
      end else if (eos) begin
        stop_string(STOP_TRUNCATED);
      end
      return;
    end
    if (cr_held) begin
      cr_held = 1'b0;
      if (b != CHAR_LF && !put_units(1, 16'(CHAR_CR), 16'h0))
        return;
    end
    if (b == 8'h00) begin
      stop_string(STOP_ZERO_BYTE);
      return;
    end
    case (b[7:4])
      4'h8, 4'h9, 4'hA, 4'hB: begin
        stop_string(STOP_BAD_LEAD);
        return;
      end
      4'hC, 4'hD: begin
        code_acc  = 21'(b[4:0]);
        cont_left = 2'd1;
      end
      4'hE: begin
        code_acc  = 21'(b[3:0]);
        cont_left = 2'd2;
      end
      4'hF: begin
        code_acc  = 21'(b[2:0]);
        cont_left = 2'd3;
      end
      default: begin
        emit_code_point(21'(b), eos);
        return;
      end
    endcase
    if (eos)
      stop_string(STOP_TRUNCATED);
  endfunction

  // Work out the results of one accepted byte and queue them for the checker.
  function automatic void decode_byte(logic [7:0] b, bit eos);
    byte_results.delete();
    if (!halted)
      take_byte(b, eos);
    if (eos) begin
      add_result(KIND_STATUS, 16'h0, units_out, halted ? halt_why : STOP_INPUT_END);
      clear_string();
    end
    if (byte_results.size() > 0)
      byte_results[byte_results.size() - 1].last_item = 1'b1;
    awaited_items = {awaited_items, byte_results};
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14)
      return 0;
    if (r < 19)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit eos);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, eos);
    bytes_sent++;
    if (eos)
      strings_sent++;
  endtask

  task automatic send_string();
    foreach (str_bytes[i])
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
  endtask

  // Drop the request line and hold until every awaited item has come back.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CRLF_MODE)
      crlf_on = value[0];
    else
      cap_limit = value;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output side: random stalls, plus a long hold-off when a test asks for one.
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      out_tready <= 1'b0;
      rx_stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (rx_gaps_on)
        rx_stall_left = pick_gap();
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic cmp_field(input string what, input logic [15:0] want,
                           input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_items.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got tdata=%h tuser=%b tlast=%b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        head_item = awaited_items.pop_front();
        cmp_field("item_kind", 16'(head_item.item_kind), 16'(out_tuser));
        cmp_field("code_unit", head_item.code_unit, out_tdata[15:0]);
        cmp_field("units_total", head_item.units_total, out_tdata[31:16]);
        cmp_field("stop_reason", 16'(head_item.stop_reason), 16'(out_tdata[34:32]));
        cmp_field("last_item", 16'(head_item.last_item), 16'(out_tlast));
        cmp_field("tdata padding", 16'h0, 16'(out_tdata[39:35]));
        items_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, no request moved for %0d cycles, %0d items still awaited",
                 $time, quiet_cycles, awaited_items.size());
        $display("** utf8_to_utf16_crlf_decoder_top: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Reset defaults: line-ending mode on, full capacity.
  task automatic test_line_endings();
    // held CR eaten by LF, overlong CR held then flushed by 'A', LF expanded, CR at end
    str_bytes = '{CHAR_CR, CHAR_LF, 8'hC0, 8'h8D, 8'h41, CHAR_LF, CHAR_CR};
    send_string();
  endtask

  task automatic test_multibyte();
    // four-byte emoji is dropped in line-ending mode, two-byte e-acute passes
    str_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC3, 8'hA9};
    send_string();
  endtask

  task automatic test_plain_mode();
    drain_results();
    write_reg(REG_CRLF_MODE, 16'h0000);
    // 0xFF taken as a four-byte lead, zero byte as continuation, code point cut to 16 bits
    str_bytes = '{8'hFF, 8'hBF, 8'h00, 8'h80, CHAR_LF};
    send_string();
  endtask

  task automatic test_early_stops();
    str_bytes = '{8'h80, 8'h41};    // stray continuation, rest ignored
    send_string();
    str_bytes = '{8'h00};
    send_string();
    str_bytes = '{8'hE2, 8'h82};    // cut short by end of string
    send_string();
  endtask

  task automatic test_capacity();
    drain_results();
    write_reg(REG_CRLF_MODE, 16'h0001);
    write_reg(REG_CAPACITY, 16'h0001);
    str_bytes = '{8'h41, CHAR_CR, 8'h42};   // held CR does not fit, 'B' ignored
    send_string();
    str_bytes = '{CHAR_LF};                 // LF needs room for two units
    send_string();
    drain_results();
    write_reg(REG_CAPACITY, 16'h0000);
    str_bytes = '{8'h7F};
    send_string();
    drain_results();
    write_reg(REG_CAPACITY, CAP_RESET);
  endtask

  task automatic test_mode_change_mid_string();
    drain_results();
    write_reg(REG_CRLF_MODE, 16'h0001);
    send_byte(CHAR_CR, 1'b0);
    drain_results();
    // the held CR is still resolved after the mode is cleared
    write_reg(REG_CRLF_MODE, 16'h0000);
    send_byte(CHAR_LF, 1'b1);
  endtask

  task automatic test_backpressure();
    bit saved_tx;
    drain_results();
    write_reg(REG_CRLF_MODE, 16'h0001);
    saved_tx   = tx_gaps_on;
    tx_gaps_on = 1'b0;
    rx_hold_left = HOLD_CYCLES;
    // each LF yields two units, so the result queue fills and stalls the input
    repeat (15) send_byte(CHAR_LF, 1'b0);
    send_byte(8'h41, 1'b1);
    drain_results();
    tx_gaps_on = saved_tx;
  endtask

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0)
      return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  task automatic build_string();
    int n_chars;
    int pick;
    str_bytes.delete();
    n_chars = $urandom_range(1, 8);
    repeat (n_chars) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        str_bytes = {str_bytes, 8'($urandom_range(1, 127))};
      end else if (pick < 45) begin
        str_bytes = {str_bytes, CHAR_LF};
      end else if (pick < 53) begin
        str_bytes = {str_bytes, CHAR_CR};
      end else if (pick < 68) begin
        str_bytes = {str_bytes, {3'b110, 5'($urandom)}};
        str_bytes = {str_bytes, cont_byte()};
      end else if (pick < 80) begin
        str_bytes = {str_bytes, {4'b1110, 4'($urandom)}};
        repeat (2) str_bytes = {str_bytes, cont_byte()};
      end else if (pick < 88) begin
        // covers the 0xF8..0xFF leads too
        str_bytes = {str_bytes, {4'b1111, 4'($urandom)}};
        repeat (3) str_bytes = {str_bytes, cont_byte()};
      end else if (pick < 92) begin
        str_bytes = {str_bytes, 8'hC0};
        str_bytes = {str_bytes,
                     {2'b10, ($urandom_range(0, 1) == 1) ? CHAR_CR[5:0] : CHAR_LF[5:0]}};
      end else if (pick < 96) begin
        str_bytes = {str_bytes, 8'($urandom)};
      end else if (pick < 98) begin
        str_bytes = {str_bytes, 8'h00};
      end else begin
        str_bytes = {str_bytes, {2'b10, 6'($urandom)}};
      end
    end
    // now and then end the string in the middle of a sequence
    if ($urandom_range(0, 7) == 0) begin
      str_bytes = {str_bytes, {3'b111, 5'($urandom)}};
      if ($urandom_range(0, 1) == 1)
        str_bytes = {str_bytes, cont_byte()};
    end
  endtask

  task automatic pick_random_setting();
    logic [15:0] cap;
    drain_results();
    case ($urandom_range(0, 5))
      0: cap = 16'h0000;
      1: cap = 16'($urandom_range(1, 4));
      2: cap = 16'($urandom_range(5, 30));
      3: cap = 16'($urandom);
      default: cap = CAP_RESET;
    endcase
    write_reg(REG_CRLF_MODE, 16'($urandom));
    write_reg(REG_CAPACITY, cap);
    tx_gaps_on = $urandom_range(0, 3) != 0;
    rx_gaps_on = $urandom_range(0, 3) != 0;
  endtask

  task automatic test_random_strings();
    int start;
    int next_setting;
    start        = bytes_sent;
    next_setting = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (bytes_sent - start >= next_setting) begin
        pick_random_setting();
        next_setting = next_setting + 40;
      end
      build_string();
      send_string();
    end
  endtask

  initial begin
    crlf_on   = 1'b1;
    cap_limit = CAP_RESET;
    clear_string();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_line_endings();
    test_multibyte();
    test_plain_mode();
    test_early_stops();
    test_capacity();
    test_mode_change_mid_string();
    test_backpressure();
    test_random_strings();

    drain_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d strings, checked %0d result items, %0d register writes.",
             bytes_sent, strings_sent, items_checked, reg_writes);
    $display("Both line-ending modes, capacities 0..65535, all stop reasons, %0d-cycle stall.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("** utf8_to_utf16_crlf_decoder_top: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** utf8_to_utf16_crlf_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/u8u16_pkg.sv
src/utf8_to_utf16_crlf_decoder_top.sv
src/u8u16_chk.sv
tb/testbench.sv
